>>> sv/frf_pkg.sv
// frf_pkg: types, constants and register codes for fasta_record_filter.
// No dependencies; imported by frf_verdict and fasta_record_filter.
`default_nettype none

package frf_pkg;

    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int LEN_W      = 32;
    localparam int ALPHA_W    = 64;
    localparam int PROD_W     = FRAC_W + COUNT_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_GT = 8'h3E;
    localparam logic [7:0] CHAR_C  = 8'h43;
    localparam logic [7:0] CHAR_G  = 8'h47;

    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RST  = '0;
    localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RST = 64'h0000_0000_0010_008A;
    localparam logic [LEN_W-1:0]   MIN_LEN_RST    = '0;
    localparam logic [LEN_W-1:0]   MAX_LEN_RST    = '1;
    localparam logic [FRAC_W-1:0]  GC_MIN_RST     = '0;
    localparam logic [FRAC_W-1:0]  GC_MAX_RST     = FRAC_W'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA_LOW  = 3'd0,
        REG_ALPHA_HIGH = 3'd1,
        REG_MIN_LENGTH = 3'd2,
        REG_MAX_LENGTH = 3'd3,
        REG_GC_MIN     = 3'd4,
        REG_GC_MAX     = 3'd5,
        REG_STRICT     = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        REQ_DATA = 1'b0,
        REQ_END  = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic                  keep;
        logic [COUNT_BITS-1:0] symbol_count;
        logic [COUNT_BITS-1:0] gc_total;
        logic                  foreign_seen;
    } rsp_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] symbols;
        logic [COUNT_BITS-1:0] gc;
        logic                  foreign;
    } rec_sum_t;

    typedef struct packed {
        logic [LEN_W-1:0]  min_length;
        logic [LEN_W-1:0]  max_length;
        logic [FRAC_W-1:0] gc_min_frac;
        logic [FRAC_W-1:0] gc_max_frac;
    } filt_cfg_t;

endpackage

`default_nettype wire

>>> sv/frf_verdict.sv
// frf_verdict: two-stage keep decision for a closed record (multiply, then compare).
// Depends on frf_pkg; instantiated by fasta_record_filter.
`default_nettype none

module frf_verdict
    import frf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      sum_valid,
    output logic           sum_stall,
    input  wire rec_sum_t  sum,
    input  wire filt_cfg_t cfg,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_t           rsp_data
);

    logic                  s2_valid_reg, s2_valid_next;
    rec_sum_t              s2_sum_reg;
    logic [PROD_W-1:0]     prod_min_reg, prod_max_reg;
    logic                  len_ok_reg;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg;
    logic                  out_ready, s2_ready;
    logic [PROD_W-1:0]     scaled_gc;
    logic                  keep;

    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign sum_stall = !s2_ready;

    always_comb
    begin
        s2_valid_next  = s2_ready  ? sum_valid    : s2_valid_reg;
        rsp_valid_next = out_ready ? s2_valid_reg : rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // stage 2: exact products and length window
    always_ff @(posedge clk)
    begin
        if (s2_ready && sum_valid)
        begin
            s2_sum_reg   <= sum;
            prod_min_reg <= PROD_W'(cfg.gc_min_frac) * PROD_W'(sum.symbols);
            prod_max_reg <= PROD_W'(cfg.gc_max_frac) * PROD_W'(sum.symbols);
            len_ok_reg   <= (LEN_W'(sum.symbols) > cfg.min_length) &&
                            (LEN_W'(sum.symbols) < cfg.max_length);
        end
    end

    assign scaled_gc = PROD_W'(s2_sum_reg.gc) << FRAC_BITS;
    assign keep = len_ok_reg && (scaled_gc >= prod_min_reg) &&
                  (scaled_gc <= prod_max_reg) && !s2_sum_reg.foreign;

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            rsp_reg.keep         <= keep;
            rsp_reg.symbol_count <= s2_sum_reg.symbols;
            rsp_reg.gc_total     <= s2_sum_reg.gc;
            rsp_reg.foreign_seen <= s2_sum_reg.foreign;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_keep_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.keep |-> !rsp_reg.foreign_seen)
        else $error("keep with foreign byte");

    a_keep_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.keep |-> rsp_reg.symbol_count != '0)
        else $error("keep on empty record");

    a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && rsp_valid_reg && rsp_stall |=> s2_valid_reg)
        else $error("stage 2 dropped under stall");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        sum_stall |-> s2_valid_reg && rsp_valid_reg)
        else $error("stall without full pipe");

endmodule

`default_nettype wire

>>> sv/fasta_record_filter.sv
// fasta_record_filter: FASTA record scanner with length and GC-content verdict.
// Depends on frf_pkg and frf_verdict.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+---------------------------------------
//  request  | req_valid | req_stall | req_data  (req_type, data_byte)
//  result   | rsp_valid | rsp_stall | rsp_data  (keep, counts, foreign)
//  config   | cfg_we    | -         | cfg_index, cfg_data
//
//  One byte per cycle while req_stall is low. rsp_valid for a record close rises once
//  the compare register loads, behind the products register that takes the close.
//  Reset starts in the header state with cleared counters and default registers.
//  req_stall rises only when both verdict stages hold results and rsp_stall is high.
`default_nettype none

module fasta_record_filter
    import frf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire req_t                  req_data,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output rsp_t                       rsp_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ALPHA_W-1:0]    alpha_low_reg, alpha_high_reg;
    filt_cfg_t             filt_reg;
    logic                  strict_reg;

    logic                  in_header_reg, in_header_next;
    logic [COUNT_BITS-1:0] sym_reg, sym_next;
    logic [COUNT_BITS-1:0] gc_reg, gc_next;
    logic                  foreign_reg, foreign_next;

    logic                  accept, is_end, closing, in_alpha, is_gc;
    logic [7:0]            b;
    logic                  sum_valid, sum_stall;
    rec_sum_t              sum;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg        <= ALPHA_LOW_RST;
            alpha_high_reg       <= ALPHA_HIGH_RST;
            filt_reg.min_length  <= MIN_LEN_RST;
            filt_reg.max_length  <= MAX_LEN_RST;
            filt_reg.gc_min_frac <= GC_MIN_RST;
            filt_reg.gc_max_frac <= GC_MAX_RST;
            strict_reg           <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ALPHA_LOW:  alpha_low_reg        <= cfg_data;
                REG_ALPHA_HIGH: alpha_high_reg       <= cfg_data;
                REG_MIN_LENGTH: filt_reg.min_length  <= cfg_data[LEN_W-1:0];
                REG_MAX_LENGTH: filt_reg.max_length  <= cfg_data[LEN_W-1:0];
                REG_GC_MIN:     filt_reg.gc_min_frac <= cfg_data[FRAC_W-1:0];
                REG_GC_MAX:     filt_reg.gc_max_frac <= cfg_data[FRAC_W-1:0];
                REG_STRICT:     strict_reg           <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign b       = req_data.data_byte;
    assign accept  = req_valid && !req_stall;
    assign is_end  = (req_data.req_type == REQ_END);
    assign closing = is_end || (!in_header_reg && b == CHAR_GT);
    assign is_gc   = (b == CHAR_C) || (b == CHAR_G);

    always_comb
    begin
        priority if (b[7])
            in_alpha = 1'b0;
        else if (b[6])
            in_alpha = alpha_high_reg[b[5:0]];
        else
            in_alpha = alpha_low_reg[b[5:0]];
    end

    // record summary; an unfinished header reports zeros
    always_comb
    begin
        sum.symbols = in_header_reg ? '0 : sym_reg;
        sum.gc      = in_header_reg ? '0 : gc_reg;
        sum.foreign = in_header_reg ? 1'b0 : foreign_reg;
    end

    always_comb
    begin
        in_header_next = in_header_reg;
        sym_next       = sym_reg;
        gc_next        = gc_reg;
        foreign_next   = foreign_reg;
        if (accept)
        begin
            priority if (closing)
            begin
                in_header_next = 1'b1;
                sym_next       = '0;
                gc_next        = '0;
                foreign_next   = 1'b0;
            end
            else if (in_header_reg)
            begin
                if (b == CHAR_LF)
                begin
                    in_header_next = 1'b0;
                    sym_next       = '0;
                    gc_next        = '0;
                    foreign_next   = 1'b0;
                end
            end
            else
            begin
                if (in_alpha)
                    sym_next = (sym_reg == '1) ? sym_reg : sym_reg + 1'b1;
                else if (strict_reg)
                    foreign_next = 1'b1;
                if (is_gc)
                    gc_next = (gc_reg == '1) ? gc_reg : gc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg <= 1'b1;
            sym_reg       <= '0;
            gc_reg        <= '0;
            foreign_reg   <= 1'b0;
        end
        else
        begin
            in_header_reg <= in_header_next;
            sym_reg       <= sym_next;
            gc_reg        <= gc_next;
            foreign_reg   <= foreign_next;
        end
    end

    assign sum_valid = req_valid && closing;
    assign req_stall = sum_stall;

    frf_verdict u_verdict (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum_stall (sum_stall),
        .sum       (sum),
        .cfg       (filt_reg),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    a_close_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        accept && closing |=> in_header_reg && sym_reg == '0 && gc_reg == '0)
        else $error("record close did not clear state");

    a_header_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_header_reg |-> sym_reg == '0 && gc_reg == '0 && !foreign_reg)
        else $error("counts moved in header");

    a_stall_needs_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stall without a held result");

endmodule

`default_nettype wire

>>> tb/frf_checker.sv
// frf_checker: watches the request, result and register ports of fasta_record_filter,
// predicts each record verdict and compares it with the block's output.
// Depends on frf_pkg.
`timescale 1ns / 1ps

module frf_checker
    import frf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  req_t                  req_data,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  rsp_t                  rsp_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    verdicts_owed
);

    logic [ALPHA_W-1:0] alpha_lo;
    logic [ALPHA_W-1:0] alpha_hi;
    filt_cfg_t          limits;
    logic               strict_mode;
    logic               in_hdr;
    rec_sum_t           tally;
    rsp_t               verdict_q[$];
    int                 errs;

    function automatic logic is_symbol(input logic [7:0] b);
        if (b[7])
            return 1'b0;
        return b[6] ? alpha_hi[b[5:0]] : alpha_lo[b[5:0]];
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic rsp_t judge_record();
        rec_sum_t    s;
        logic [63:0] gc_scaled;
        logic [63:0] lo_bound;
        logic [63:0] hi_bound;
        rsp_t        r;
        s = in_hdr ? rec_sum_t'('0) : tally;
        gc_scaled = 64'(s.gc) << FRAC_BITS;
        lo_bound = 64'(limits.gc_min_frac) * 64'(s.symbols);
        hi_bound = 64'(limits.gc_max_frac) * 64'(s.symbols);
        r.keep = (s.symbols > limits.min_length) && (s.symbols < limits.max_length)
            && (gc_scaled >= lo_bound) && (gc_scaled <= hi_bound) && !s.foreign;
        r.symbol_count = s.symbols;
        r.gc_total = s.gc;
        r.foreign_seen = s.foreign;
        return r;
    endfunction

    task automatic close_record();
        verdict_q.push_back(judge_record());
        tally = '0;
        in_hdr = 1'b1;
    endtask

    task automatic scan_request(input req_t q);
        if (q.req_type == REQ_END)
            close_record();
        else if (in_hdr)
        begin
            if (q.data_byte == CHAR_LF)
            begin
                in_hdr = 1'b0;
                tally = '0;
            end
        end
        else if (q.data_byte == CHAR_GT)
            close_record();
        else
        begin
            if (is_symbol(q.data_byte))
                tally.symbols = bump(tally.symbols);
            else if (strict_mode)
                tally.foreign = 1'b1;
            if (q.data_byte == CHAR_C || q.data_byte == CHAR_G)
                tally.gc = bump(tally.gc);
        end
    endtask

    task automatic report(input string what, input rsp_t e, input rsp_t a);
        errs++;
        if (errs <= 10)
        begin
            $write("%0t: %s: expected keep=%0d symbols=%0d gc=%0d foreign=%0d, ",
                $time, what, e.keep, e.symbol_count, e.gc_total, e.foreign_seen);
            $display("got keep=%0d symbols=%0d gc=%0d foreign=%0d",
                a.keep, a.symbol_count, a.gc_total, a.foreign_seen);
        end
    endtask

    task automatic check_verdict(input rsp_t a);
        rsp_t e;
        if (verdict_q.size() == 0)
        begin
            report("verdict with none pending", '0, a);
            return;
        end
        e = verdict_q.pop_front();
        if (e.keep !== a.keep || e.symbol_count !== a.symbol_count
            || e.gc_total !== a.gc_total || e.foreign_seen !== a.foreign_seen)
            report("verdict mismatch", e, a);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_lo = ALPHA_LOW_RST;
            alpha_hi = ALPHA_HIGH_RST;
            limits.min_length = MIN_LEN_RST;
            limits.max_length = MAX_LEN_RST;
            limits.gc_min_frac = GC_MIN_RST;
            limits.gc_max_frac = GC_MAX_RST;
            strict_mode = 1'b0;
            in_hdr = 1'b1;
            tally = '0;
            verdict_q.delete();
            errs = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_verdict(rsp_data);
            if (req_valid && !req_stall)
                scan_request(req_data);
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ALPHA_LOW:  alpha_lo = cfg_data;
                    REG_ALPHA_HIGH: alpha_hi = cfg_data;
                    REG_MIN_LENGTH: limits.min_length = cfg_data[LEN_W-1:0];
                    REG_MAX_LENGTH: limits.max_length = cfg_data[LEN_W-1:0];
                    REG_GC_MIN:     limits.gc_min_frac = cfg_data[FRAC_W-1:0];
                    REG_GC_MAX:     limits.gc_max_frac = cfg_data[FRAC_W-1:0];
                    REG_STRICT:     strict_mode = cfg_data[0];
                    default: ;
                endcase
            end
        end
        mismatches <= errs;
        verdicts_owed <= verdict_q.size();
    end

endmodule

>>> tb/tb_top.sv
// tb_top: stimulus and verdict for fasta_record_filter; the checking lives in frf_checker.
// Depends on frf_pkg, frf_checker and the RTL of fasta_record_filter.
`timescale 1ns / 1ps

module tb_top;
    import frf_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 400000;
    localparam logic [ALPHA_W-1:0] ALPHA_LOWER = (64'h1 << 33) | (64'h1 << 35)
        | (64'h1 << 39) | (64'h1 << 46) | (64'h1 << 52);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req_data = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp_data;
    logic                  cfg_we = 1'b0;
    cfg_reg_t              cfg_index = REG_ALPHA_LOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int verdicts_owed;
    int cycles = 0;
    int idle_pct = 30;
    bit hold_results = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    fasta_record_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frf_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_data      (rsp_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .verdicts_owed (verdicts_owed)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else
            begin
                n = idle_len();
                if (n > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic send_req(input req_kind_t k, input logic [7:0] b);
        int g;
        g = idle_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= '{req_type: k, data_byte: b};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // wait first so the owed count includes the last request taken
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
    endtask

    task automatic set_filter(input logic [63:0] alo, input logic [63:0] ahi,
                              input logic [31:0] min_len, input logic [31:0] max_len,
                              input logic [16:0] gmin, input logic [16:0] gmax,
                              input logic strict);
        drain();
        write_reg(REG_ALPHA_LOW, alo);
        write_reg(REG_ALPHA_HIGH, ahi);
        write_reg(REG_MIN_LENGTH, 64'(min_len));
        write_reg(REG_MAX_LENGTH, 64'(max_len));
        write_reg(REG_GC_MIN, 64'(gmin));
        write_reg(REG_GC_MAX, 64'(gmax));
        write_reg(REG_STRICT, 64'(strict));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] seq_byte();
        int          r;
        logic [7:0]  b;
        logic [31:0] bases;
        r = $urandom_range(0, 99);
        bases = "ACGT";
        if (r < 60)
            return bases[8 * $urandom_range(0, 3) +: 8];
        if (r < 75)
        begin
            bases = "acgt";
            return ($urandom_range(0, 4) == 0) ? 8'h6E : bases[8 * $urandom_range(0, 3) +: 8];
        end
        if (r < 95)
        begin
            b = 8'($urandom_range(0, 255));
            return (b == CHAR_GT) ? 8'h3F : b;
        end
        return $urandom_range(0, 1) ? CHAR_C : CHAR_G;
    endfunction

    // header, line feed, sequence, then close by '>' or end of input
    task automatic send_record(input int max_len);
        logic [7:0] b;
        repeat ($urandom_range(0, 4))
        begin
            b = 8'($urandom_range(0, 255));
            send_req(REQ_DATA, (b == CHAR_LF) ? 8'h20 : b);
        end
        send_req(REQ_DATA, CHAR_LF);
        repeat ($urandom_range(0, max_len))
            send_req(REQ_DATA, seq_byte());
        if ($urandom_range(0, 3) == 0)
            send_req(REQ_END, 8'($urandom_range(0, 255)));
        else
            send_req(REQ_DATA, CHAR_GT);
    endtask

    task automatic run_phase(input int n_items, input int max_len, input int pct);
        idle_pct = pct;
        repeat (n_items / (max_len / 2 + 4))
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6))
                    send_req(($urandom_range(0, 7) == 0) ? REQ_END : REQ_DATA,
                             8'($urandom_range(0, 255)));
            else
                send_record(max_len);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: header never closed, then bases, case, non-ASCII and LF in sequence
        send_req(REQ_END, 8'h5A);
        send_req(REQ_DATA, "x");
        send_req(REQ_DATA, CHAR_LF);
        send_req(REQ_DATA, "A");
        send_req(REQ_DATA, "C");
        send_req(REQ_DATA, "G");
        send_req(REQ_DATA, "T");
        send_req(REQ_DATA, "c");
        send_req(REQ_DATA, "g");
        send_req(REQ_DATA, 8'h00);
        send_req(REQ_DATA, 8'hFF);
        send_req(REQ_DATA, 8'h80);
        send_req(REQ_DATA, CHAR_LF);
        send_req(REQ_DATA, CHAR_GT);
        send_req(REQ_DATA, CHAR_GT);
        send_req(REQ_DATA, CHAR_LF);
        send_req(REQ_DATA, "G");
        send_req(REQ_DATA, "G");
        send_req(REQ_END, 8'hFF);
        send_req(REQ_DATA, CHAR_LF);
        send_req(REQ_END, 8'h00);

        set_filter(64'h0, ALPHA_HIGH_RST | ALPHA_LOWER, 2, 25, 17'd16384, 17'd49152, 1'b1);
        send_req(REQ_DATA, CHAR_LF);
        send_req(REQ_DATA, "A");
        send_req(REQ_DATA, "N");
        send_req(REQ_END, 8'h00);
        run_phase(200, 30, 30);

        // long result stall while requests keep coming
        idle_pct = 0;
        hold_results = 1'b1;
        run_phase(120, 3, 0);

        set_filter('1, '1, 32'h0, 32'hFFFF_FFFF, 17'd0, 17'd65536, 1'b0);
        run_phase(200, 40, 20);

        set_filter(64'h0, 64'h0, 32'hFFFF_FFFF, 32'h0, 17'h1FFFF, 17'h1FFFF, 1'b1);
        run_phase(150, 20, 50);

        // no C or G in the alphabet, so fractions above one happen
        set_filter(64'h0, (64'h1 << 1) | (64'h1 << 20), 0, 32'hFFFF_FFFF,
                   17'd65536, 17'h1FFFF, 1'b0);
        run_phase(150, 20, 10);

        repeat (5)
        begin
            set_filter({$urandom, $urandom},
                       {$urandom, $urandom} | ($urandom_range(0, 1) ? ALPHA_HIGH_RST : 64'h0),
                       $urandom_range(0, 8),
                       ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(3, 45),
                       17'($urandom_range(0, 40000)), 17'($urandom_range(20000, 131071)),
                       1'($urandom_range(0, 1)));
            case ($urandom_range(0, 2))
                0: run_phase(150, 25, 0);
                1: run_phase(150, 25, 15);
                default: run_phase(150, 25, 40);
            endcase
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
